// ===== sv/rdmc_pkg.sv =====
package rdmc_pkg;

  // Default grid and backtracking limits
  localparam int GRID_W_DEF = 20;
  localparam int GRID_H_DEF = 20;
  localparam int TRIES_DEF  = 30;

  // Fixed field widths
  localparam int COORD_W   = 5;
  localparam int TRY_W     = 6;
  localparam int WALL_W    = 4;
  localparam int FAR_LEN_W = 9;
  localparam int FAR_MAX   = (1 << FAR_LEN_W) - 1;
  localparam int CFG_W     = 32;
  localparam int PADDR_W   = 3;

  localparam logic [WALL_W-1:0] WALLS_ALL = 4'd15;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // Register indexes of the configuration port
  typedef enum logic {
    REG_START_X = 1'b0,
    REG_START_Y = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_CLR,
    S_PUSH0,
    S_TRY,
    S_CHK,
    S_CARVE,
    S_POP,
    S_POP_LD,
    S_RD,
    S_RDW,
    S_FIN
  } state_t;

  // One entry of the cell store
  typedef struct packed {
    logic              visited;
    logic [WALL_W-1:0] walls;
  } cell_t;

  // One frame of the backtracking stack
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TRY_W-1:0]   tries;
  } frame_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic clr_init;
    logic clr_step;
    logic start_push;
    logic try_issue;
    logic carve_nb;
    logic carve_cur;
    logic pop;
    logic pop_load;
    logic rd_issue;
    logic rd_load;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic depth_zero;
    logic depth_one;
    logic nb_free;
    logic top_exh;
    logic out_free;
  } ctrl_sts_t;

  // Wall bit facing a direction
  function automatic logic [WALL_W-1:0] dir_mask(input dir_t d);
    logic [WALL_W-1:0] m;
    case (d)
      DIR_UP:    m = 4'd1;
      DIR_DOWN:  m = 4'd2;
      DIR_RIGHT: m = 4'd4;
      DIR_LEFT:  m = 4'd8;
      default:   m = '0;
    endcase
    return m;
  endfunction

  function automatic dir_t dir_opp(input dir_t d);
    dir_t o;
    case (d)
      DIR_UP:    o = DIR_DOWN;
      DIR_DOWN:  o = DIR_UP;
      DIR_RIGHT: o = DIR_LEFT;
      DIR_LEFT:  o = DIR_RIGHT;
      default:   o = DIR_UP;
    endcase
    return o;
  endfunction

endpackage

// ===== sv/random_dfs_maze_carver_core.sv =====
// Randomized depth-first maze carver.
// Input channel (in_valid / in_stall) carries one operation per transaction:
// start a new maze, apply one random direction draw, read the walls of a
// cell, or do nothing. Every input transaction yields exactly one result
// transaction on the output channel (out_valid / out_stall) with the stack,
// farthest cell and wall status after the operation.
// A start clears the whole cell store, then pushes the start cell if it lies
// on the grid; a draw that does not carve pops every exhausted frame from
// the stack; a draw on an empty stack changes nothing.
// A new transaction is accepted in the cycle after the result is registered.
// The cell store and frame stack are single-write, registered-read memories;
// each step of the walk takes one memory access per cycle. After reset the
// block sweeps every cell of the cell store with in_stall high;
// configuration writes are taken meanwhile.
// A stalled result holds in the output register; the next transaction can
// be accepted and worked on while it waits, and finishes only once the
// register is free. start_x/start_y are written over the APB-style port.
module random_dfs_maze_carver_core #(
  parameter int GRID_W         = rdmc_pkg::GRID_W_DEF,
  parameter int GRID_H         = rdmc_pkg::GRID_H_DEF,
  parameter int TRIES_PER_CELL = rdmc_pkg::TRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rdmc_pkg::PADDR_W-1:0]     paddr,
  input  logic [rdmc_pkg::CFG_W-1:0]       pwdata,
  output logic [rdmc_pkg::CFG_W-1:0]       prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [1:0]                       in_dir_draw,
  input  logic [rdmc_pkg::COORD_W-1:0]     in_read_x,
  input  logic [rdmc_pkg::COORD_W-1:0]     in_read_y,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_finished,
  output logic                             out_carved,
  output logic [rdmc_pkg::COORD_W-1:0]     out_top_x,
  output logic [rdmc_pkg::COORD_W-1:0]     out_top_y,
  output logic [rdmc_pkg::COORD_W-1:0]     out_far_x,
  output logic [rdmc_pkg::COORD_W-1:0]     out_far_y,
  output logic [rdmc_pkg::FAR_LEN_W-1:0]   out_far_len,
  output logic [rdmc_pkg::WALL_W-1:0]      out_cell_walls
);

  import rdmc_pkg::*;

  logic [COORD_W-1:0] start_x_r;
  logic [COORD_W-1:0] start_y_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;

  // Register file: one 32-bit word per register
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_X: start_x_r <= pwdata[COORD_W-1:0];
        REG_START_Y: start_y_r <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_X: prdata = CFG_W'(start_x_r);
      REG_START_Y: prdata = CFG_W'(start_y_r);
      default:     prdata = '0;
    endcase
  end

  rdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (op_t'(in_opcode)),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdmc_dp #(
    .GRID_W         (GRID_W),
    .GRID_H         (GRID_H),
    .TRIES_PER_CELL (TRIES_PER_CELL)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_dir_draw    (in_dir_draw),
    .in_read_x      (in_read_x),
    .in_read_y      (in_read_y),
    .start_x        (start_x_r),
    .start_y        (start_y_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_finished   (out_finished),
    .out_carved     (out_carved),
    .out_top_x      (out_top_x),
    .out_top_y      (out_top_y),
    .out_far_x      (out_far_x),
    .out_far_y      (out_far_y),
    .out_far_len    (out_far_len),
    .out_cell_walls (out_cell_walls)
  );

  // An accepted transaction stalls the input in the following cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  // An empty stack reports no top cell
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_top_x == '0 && out_top_y == '0))
    else $error("finished result with nonzero top cell");

  // A carve always leaves the pushed cell on the stack
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_carved) |-> !out_finished)
    else $error("carved result reports an empty stack");

  // Only one of the controller's cell store writers is active at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.start_push, cmd.carve_nb, cmd.carve_cur}))
    else $error("conflicting cell store writes");

endmodule

// ===== sv/rdmc_ram.sv =====
module rdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rdmc_ctrl.sv =====
module rdmc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rdmc_pkg::op_t         in_op,
  output logic                  in_stall,
  input  rdmc_pkg::ctrl_sts_t   sts,
  output rdmc_pkg::ctrl_cmd_t   cmd
);

  import rdmc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT_CLR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_START: state_nxt = S_CLR;
            OP_DRAW:  state_nxt = S_TRY;
            OP_READ:  state_nxt = S_RD;
            default:  state_nxt = S_FIN;
          endcase
        end
      end
      S_CLR:    if (sts.clr_last) state_nxt = S_PUSH0;
      S_PUSH0:  state_nxt = S_FIN;
      S_TRY:    state_nxt = sts.depth_zero ? S_FIN : S_CHK;
      S_CHK:    state_nxt = sts.nb_free ? S_CARVE : S_POP;
      S_CARVE:  state_nxt = S_FIN;
      S_POP: begin
        if (!sts.depth_zero && sts.top_exh && !sts.depth_one) begin
          state_nxt = S_POP_LD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_POP_LD: state_nxt = S_POP;
      S_RD:     state_nxt = S_RDW;
      S_RDW:    state_nxt = S_FIN;
      S_FIN:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT_CLR;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_INIT_CLR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.latch_in = in_valid;
        cmd.clr_init = in_valid && (in_op == OP_START);
      end
      S_CLR:    cmd.clr_step   = 1'b1;
      S_PUSH0:  cmd.start_push = 1'b1;
      S_TRY:    cmd.try_issue  = !sts.depth_zero;
      S_CHK:    cmd.carve_nb   = sts.nb_free;
      S_CARVE:  cmd.carve_cur  = 1'b1;
      S_POP:    cmd.pop        = !sts.depth_zero && sts.top_exh;
      S_POP_LD: cmd.pop_load   = 1'b1;
      S_RD:     cmd.rd_issue   = 1'b1;
      S_RDW:    cmd.rd_load    = 1'b1;
      S_FIN:    cmd.out_load   = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== sv/rdmc_dp.sv =====
module rdmc_dp #(
  parameter int GRID_W         = rdmc_pkg::GRID_W_DEF,
  parameter int GRID_H         = rdmc_pkg::GRID_H_DEF,
  parameter int TRIES_PER_CELL = rdmc_pkg::TRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rdmc_pkg::ctrl_cmd_t              cmd,
  output rdmc_pkg::ctrl_sts_t              sts,
  input  logic [1:0]                       in_dir_draw,
  input  logic [rdmc_pkg::COORD_W-1:0]     in_read_x,
  input  logic [rdmc_pkg::COORD_W-1:0]     in_read_y,
  input  logic [rdmc_pkg::COORD_W-1:0]     start_x,
  input  logic [rdmc_pkg::COORD_W-1:0]     start_y,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic                             out_finished,
  output logic                             out_carved,
  output logic [rdmc_pkg::COORD_W-1:0]     out_top_x,
  output logic [rdmc_pkg::COORD_W-1:0]     out_top_y,
  output logic [rdmc_pkg::COORD_W-1:0]     out_far_x,
  output logic [rdmc_pkg::COORD_W-1:0]     out_far_y,
  output logic [rdmc_pkg::FAR_LEN_W-1:0]   out_far_len,
  output logic [rdmc_pkg::WALL_W-1:0]      out_cell_walls
);

  import rdmc_pkg::*;

  localparam int NCELLS = GRID_W * GRID_H;
  localparam int IDX_W  = $clog2(NCELLS);
  localparam int DEP_W  = $clog2(NCELLS + 1);

  // Latched transaction fields
  dir_t               dir_r;
  logic [COORD_W-1:0] rx_r;
  logic [COORD_W-1:0] ry_r;

  // Walk state
  logic [IDX_W-1:0]   clr_cnt_r;
  logic [DEP_W-1:0]   depth_r;
  logic [COORD_W-1:0] top_x_r;
  logic [COORD_W-1:0] top_y_r;
  logic [TRY_W-1:0]   top_tries_r;
  logic [COORD_W-1:0] nx_r;
  logic [COORD_W-1:0] ny_r;
  logic               nb_ok_r;
  logic [IDX_W-1:0]   nidx_r;
  logic [COORD_W-1:0] far_x_r;
  logic [COORD_W-1:0] far_y_r;
  logic [DEP_W-1:0]   far_len_r;
  logic               carved_r;
  logic [WALL_W-1:0]  walls_r;

  // Result register
  logic                 out_valid_r;
  logic                 out_finished_r;
  logic                 out_carved_r;
  logic [COORD_W-1:0]   out_top_x_r;
  logic [COORD_W-1:0]   out_top_y_r;
  logic [COORD_W-1:0]   out_far_x_r;
  logic [COORD_W-1:0]   out_far_y_r;
  logic [FAR_LEN_W-1:0] out_far_len_r;
  logic [WALL_W-1:0]    out_cell_walls_r;

  // Memory ports
  logic             cell_we;
  logic [IDX_W-1:0] cell_waddr;
  cell_t            cell_wdata;
  logic [IDX_W-1:0] cell_raddr;
  cell_t            cell_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;
  frame_t           stk_wdata;
  logic [IDX_W-1:0] stk_raddr;
  frame_t           stk_rdata;

  // Address arithmetic
  logic [COORD_W-1:0] nx;
  logic [COORD_W-1:0] ny;
  logic               nb_ok;
  logic [IDX_W-1:0]   nb_idx;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   start_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               start_in;
  logic               rd_in;
  logic               depth_zero;

  assign cur_idx   = IDX_W'(32'(top_y_r) * GRID_W + 32'(top_x_r));
  assign nb_idx    = IDX_W'(32'(ny) * GRID_W + 32'(nx));
  assign start_idx = IDX_W'(32'(start_y) * GRID_W + 32'(start_x));
  assign rd_idx    = IDX_W'(32'(ry_r) * GRID_W + 32'(rx_r));
  assign start_in  = (32'(start_x) < GRID_W) && (32'(start_y) < GRID_H);
  assign rd_in     = (32'(rx_r) < GRID_W) && (32'(ry_r) < GRID_H);
  assign depth_zero = (depth_r == '0);

  // Neighbor of the top cell in the drawn direction
  always_comb begin
    nx    = top_x_r;
    ny    = top_y_r;
    nb_ok = 1'b1;
    case (dir_r)
      DIR_UP: begin
        if (top_y_r == '0) nb_ok = 1'b0;
        else ny = top_y_r - COORD_W'(1);
      end
      DIR_DOWN: begin
        if (32'(top_y_r) + 1 >= GRID_H) nb_ok = 1'b0;
        else ny = top_y_r + COORD_W'(1);
      end
      DIR_RIGHT: begin
        if (32'(top_x_r) + 1 >= GRID_W) nb_ok = 1'b0;
        else nx = top_x_r + COORD_W'(1);
      end
      DIR_LEFT: begin
        if (top_x_r == '0) nb_ok = 1'b0;
        else nx = top_x_r - COORD_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // Cell store access
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_cnt_r;
    cell_wdata = '{visited: 1'b0, walls: WALLS_ALL};
    if (cmd.clr_step) begin
      cell_we = 1'b1;
    end else if (cmd.start_push) begin
      cell_we    = start_in;
      cell_waddr = start_idx;
      cell_wdata = '{visited: 1'b1, walls: WALLS_ALL};
    end else if (cmd.carve_nb) begin
      cell_we    = 1'b1;
      cell_waddr = nidx_r;
      cell_wdata = '{visited: 1'b1, walls: WALLS_ALL & ~dir_mask(dir_opp(dir_r))};
    end else if (cmd.carve_cur) begin
      cell_we    = 1'b1;
      cell_waddr = cur_idx;
      cell_wdata = '{visited: 1'b1, walls: cell_rdata.walls & ~dir_mask(dir_r)};
    end
  end

  always_comb begin
    cell_raddr = '0;
    if (cmd.try_issue) begin
      cell_raddr = nb_ok ? nb_idx : '0;
    end else if (cmd.carve_nb) begin
      cell_raddr = cur_idx;
    end else if (cmd.rd_issue) begin
      cell_raddr = rd_in ? rd_idx : '0;
    end
  end

  // Frame stack access
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '{x: start_x, y: start_y, tries: '0};
    if (cmd.try_issue) begin
      stk_we    = 1'b1;
      stk_waddr = IDX_W'(depth_r - DEP_W'(1));
      stk_wdata = '{x: top_x_r, y: top_y_r, tries: top_tries_r + TRY_W'(1)};
    end else if (cmd.start_push) begin
      stk_we = start_in;
    end else if (cmd.carve_cur) begin
      stk_we    = 1'b1;
      stk_waddr = IDX_W'(depth_r);
      stk_wdata = '{x: nx_r, y: ny_r, tries: '0};
    end
  end

  assign stk_raddr = (cmd.pop && (depth_r > DEP_W'(1))) ?
                     IDX_W'(depth_r - DEP_W'(2)) : '0;

  rdmc_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (NCELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  rdmc_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (NCELLS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Control state: sweep counter, depth, farthest cell, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      depth_r     <= '0;
      far_x_r     <= '0;
      far_y_r     <= '0;
      far_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_init) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end

      if (cmd.clr_init) begin
        depth_r   <= '0;
        far_x_r   <= '0;
        far_y_r   <= '0;
        far_len_r <= '0;
      end else if (cmd.start_push && start_in) begin
        depth_r <= DEP_W'(1);
      end else if (cmd.carve_cur) begin
        depth_r <= depth_r + DEP_W'(1);
        // pushed cell sits at depth equal to the old stack depth
        if (depth_r > far_len_r) begin
          far_x_r   <= nx_r;
          far_y_r   <= ny_r;
          far_len_r <= depth_r;
        end
      end else if (cmd.pop) begin
        depth_r <= depth_r - DEP_W'(1);
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      dir_r    <= dir_t'(in_dir_draw);
      rx_r     <= in_read_x;
      ry_r     <= in_read_y;
      carved_r <= 1'b0;
      walls_r  <= '0;
    end

    if (cmd.start_push) begin
      top_x_r     <= start_x;
      top_y_r     <= start_y;
      top_tries_r <= '0;
    end else if (cmd.try_issue) begin
      top_tries_r <= top_tries_r + TRY_W'(1);
      nx_r        <= nx;
      ny_r        <= ny;
      nb_ok_r     <= nb_ok;
      nidx_r      <= nb_idx;
    end else if (cmd.carve_cur) begin
      top_x_r     <= nx_r;
      top_y_r     <= ny_r;
      top_tries_r <= '0;
      carved_r    <= 1'b1;
    end else if (cmd.pop_load) begin
      top_x_r     <= stk_rdata.x;
      top_y_r     <= stk_rdata.y;
      top_tries_r <= stk_rdata.tries;
    end

    if (cmd.rd_load && rd_in) begin
      walls_r <= cell_rdata.walls;
    end

    if (cmd.out_load) begin
      out_finished_r   <= depth_zero;
      out_carved_r     <= carved_r;
      out_top_x_r      <= depth_zero ? '0 : top_x_r;
      out_top_y_r      <= depth_zero ? '0 : top_y_r;
      out_far_x_r      <= far_x_r;
      out_far_y_r      <= far_y_r;
      out_cell_walls_r <= walls_r;
      if (32'(far_len_r) > FAR_MAX) begin
        out_far_len_r <= FAR_LEN_W'(FAR_MAX);
      end else begin
        out_far_len_r <= FAR_LEN_W'(far_len_r);
      end
    end
  end

  // Status to the controller
  assign sts.clr_last   = (clr_cnt_r == IDX_W'(NCELLS - 1));
  assign sts.depth_zero = depth_zero;
  assign sts.depth_one  = (depth_r == DEP_W'(1));
  assign sts.nb_free    = nb_ok_r && !cell_rdata.visited;
  assign sts.top_exh    = (32'(top_tries_r) >= TRIES_PER_CELL);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_finished   = out_finished_r;
  assign out_carved     = out_carved_r;
  assign out_top_x      = out_top_x_r;
  assign out_top_y      = out_top_y_r;
  assign out_far_x      = out_far_x_r;
  assign out_far_y      = out_far_y_r;
  assign out_far_len    = out_far_len_r;
  assign out_cell_walls = out_cell_walls_r;

endmodule

// ===== tb/maze_carver_checker.sv =====
module maze_carver_checker #(
  parameter int GRID_W         = rdmc_pkg::GRID_W_DEF,
  parameter int GRID_H         = rdmc_pkg::GRID_H_DEF,
  parameter int TRIES_PER_CELL = rdmc_pkg::TRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdmc_pkg::PADDR_W-1:0]   paddr,
  input  logic [rdmc_pkg::CFG_W-1:0]     pwdata,
  input  logic                           pready,
  // input channel
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [1:0]                     in_dir_draw,
  input  logic [rdmc_pkg::COORD_W-1:0]   in_read_x,
  input  logic [rdmc_pkg::COORD_W-1:0]   in_read_y,
  // result channel
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_finished,
  input  logic                           out_carved,
  input  logic [rdmc_pkg::COORD_W-1:0]   out_top_x,
  input  logic [rdmc_pkg::COORD_W-1:0]   out_top_y,
  input  logic [rdmc_pkg::COORD_W-1:0]   out_far_x,
  input  logic [rdmc_pkg::COORD_W-1:0]   out_far_y,
  input  logic [rdmc_pkg::FAR_LEN_W-1:0] out_far_len,
  input  logic [rdmc_pkg::WALL_W-1:0]    out_cell_walls,
  // to the testbench top
  output int                             fail_count,
  output int                             pending_count
);

  import rdmc_pkg::*;

  localparam int NCELLS = GRID_W * GRID_H;

  typedef struct packed {
    logic                 finished;
    logic                 carved;
    logic [COORD_W-1:0]   top_x;
    logic [COORD_W-1:0]   top_y;
    logic [COORD_W-1:0]   far_x;
    logic [COORD_W-1:0]   far_y;
    logic [FAR_LEN_W-1:0] far_len;
    logic [WALL_W-1:0]    walls;
  } maze_status_t;

  // Shadow maze: cell walls, visited marks and the backtracking trail
  logic [WALL_W-1:0]  wall_map    [NCELLS];
  bit                 visited_map [NCELLS];
  logic [COORD_W-1:0] trail_x     [NCELLS];
  logic [COORD_W-1:0] trail_y     [NCELLS];
  int                 trail_tries [NCELLS];
  int                 trail_depth;
  logic [COORD_W-1:0] far_cx, far_cy;
  int                 far_dist;
  logic [COORD_W-1:0] start_col, start_row;

  maze_status_t status_q[$];
  int           fail_total = 0;

  assign fail_count = fail_total;

  function automatic int cell_at(int x, int y);
    return y * GRID_W + x;
  endfunction

  function automatic void push_frame(int x, int y);
    if (trail_depth >= NCELLS) return;
    visited_map[cell_at(x, y)] = 1'b1;
    trail_x[trail_depth]     = COORD_W'(x);
    trail_y[trail_depth]     = COORD_W'(y);
    trail_tries[trail_depth] = 0;
    // path length equals depth on the trail; only a strictly longer one wins
    if (trail_depth > far_dist) begin
      far_cx   = COORD_W'(x);
      far_cy   = COORD_W'(y);
      far_dist = trail_depth;
    end
    trail_depth++;
  endfunction

  function automatic void clear_maze();
    foreach (wall_map[i]) wall_map[i] = WALLS_ALL;
    foreach (visited_map[i]) visited_map[i] = 1'b0;
    trail_depth = 0;
    far_cx      = '0;
    far_cy      = '0;
    far_dist    = 0;
    // a start cell off the grid leaves the maze finished at once
    if (start_col < GRID_W && start_row < GRID_H)
      push_frame(int'(start_col), int'(start_row));
  endfunction

  function automatic void reset_maze();
    foreach (wall_map[i]) wall_map[i] = WALLS_ALL;
    foreach (visited_map[i]) visited_map[i] = 1'b0;
    foreach (trail_tries[i]) begin
      trail_x[i]     = '0;
      trail_y[i]     = '0;
      trail_tries[i] = 0;
    end
    trail_depth = 0;
    far_cx      = '0;
    far_cy      = '0;
    far_dist    = 0;
    start_col   = '0;
    start_row   = '0;
  endfunction

  // One try of the top frame, then drop every exhausted frame
  function automatic bit take_draw(dir_t d);
    int cx, cy, nx, ny;
    bit open, carved;
    if (trail_depth == 0) return 1'b0;
    carved = 1'b0;
    open   = 1'b1;
    trail_tries[trail_depth-1]++;
    cx = int'(trail_x[trail_depth-1]);
    cy = int'(trail_y[trail_depth-1]);
    nx = cx;
    ny = cy;
    case (d)
      DIR_UP:    if (cy == 0) open = 1'b0; else ny = cy - 1;
      DIR_DOWN:  if (cy + 1 >= GRID_H) open = 1'b0; else ny = cy + 1;
      DIR_RIGHT: if (cx + 1 >= GRID_W) open = 1'b0; else nx = cx + 1;
      default:   if (cx == 0) open = 1'b0; else nx = cx - 1;
    endcase
    if (open && !visited_map[cell_at(nx, ny)]) begin
      wall_map[cell_at(cx, cy)] &= ~(4'b0001 << d);
      wall_map[cell_at(nx, ny)] &= ~(4'b0001 << (d ^ 2'd1));
      push_frame(nx, ny);
      carved = 1'b1;
    end
    while (trail_depth > 0 && trail_tries[trail_depth-1] >= TRIES_PER_CELL)
      trail_depth--;
    return carved;
  endfunction

  function automatic maze_status_t maze_status_after(op_t op, dir_t d,
                                                     logic [COORD_W-1:0] rx,
                                                     logic [COORD_W-1:0] ry);
    maze_status_t s;
    s = '0;
    case (op)
      OP_START: clear_maze();
      OP_DRAW:  s.carved = take_draw(d);
      OP_READ:  if (rx < GRID_W && ry < GRID_H) s.walls = wall_map[cell_at(rx, ry)];
      default:  ;
    endcase
    s.finished = (trail_depth == 0);
    if (trail_depth > 0) begin
      s.top_x = trail_x[trail_depth-1];
      s.top_y = trail_y[trail_depth-1];
    end
    s.far_x   = far_cx;
    s.far_y   = far_cy;
    s.far_len = (far_dist > FAR_MAX) ? FAR_LEN_W'(FAR_MAX) : FAR_LEN_W'(far_dist);
    return s;
  endfunction

  task automatic check_field(string name, logic [FAR_LEN_W-1:0] want,
                             logic [FAR_LEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  // Results are compared before the same edge's input is predicted
  always @(posedge clk) begin
    maze_status_t want, got;
    if (!rst_n) begin
      reset_maze();
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_finished, out_carved, out_top_x, out_top_y,
               out_far_x, out_far_y, out_far_len, out_cell_walls};
        if (status_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, got %h", $time, got);
          fail_total++;
        end else begin
          want = status_q.pop_front();
          check_field("finished", want.finished, got.finished);
          check_field("carved", want.carved, got.carved);
          check_field("top_x", want.top_x, got.top_x);
          check_field("top_y", want.top_y, got.top_y);
          check_field("far_x", want.far_x, got.far_x);
          check_field("far_y", want.far_y, got.far_y);
          check_field("far_len", want.far_len, got.far_len);
          check_field("cell_walls", want.walls, got.walls);
        end
      end
      if (in_valid && !in_stall)
        status_q.push_back(maze_status_after(op_t'(in_opcode), dir_t'(in_dir_draw),
                                             in_read_x, in_read_y));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_START_X: start_col = pwdata[COORD_W-1:0];
          default:     start_row = pwdata[COORD_W-1:0];
        endcase
      end
    end
    pending_count <= status_q.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import rdmc_pkg::*;

  localparam int GRID_W         = GRID_W_DEF;
  localparam int GRID_H         = GRID_H_DEF;
  localparam int TRIES_PER_CELL = TRIES_DEF;
  localparam int ITEM_TARGET    = 1950;
  // longest quiet stretch: a full chain of pops or a clearing sweep, plus stalls
  localparam int WATCHDOG_LIMIT = 8000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [PADDR_W-1:0]   paddr     = '0;
  logic [CFG_W-1:0]     pwdata    = '0;
  logic [CFG_W-1:0]     prdata;
  logic                 pready;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = OP_NOP;
  logic [1:0]           in_dir_draw = DIR_UP;
  logic [COORD_W-1:0]   in_read_x = '0;
  logic [COORD_W-1:0]   in_read_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_finished;
  logic                 out_carved;
  logic [COORD_W-1:0]   out_top_x;
  logic [COORD_W-1:0]   out_top_y;
  logic [COORD_W-1:0]   out_far_x;
  logic [COORD_W-1:0]   out_far_y;
  logic [FAR_LEN_W-1:0] out_far_len;
  logic [WALL_W-1:0]    out_cell_walls;

  int fail_count;
  int pending_count;
  int burst_left  = 0;
  int idle_cycles = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  random_dfs_maze_carver_core #(
    .GRID_W(GRID_W), .GRID_H(GRID_H), .TRIES_PER_CELL(TRIES_PER_CELL)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_dir_draw(in_dir_draw), .in_read_x(in_read_x), .in_read_y(in_read_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_finished(out_finished),
    .out_carved(out_carved), .out_top_x(out_top_x), .out_top_y(out_top_y),
    .out_far_x(out_far_x), .out_far_y(out_far_y), .out_far_len(out_far_len),
    .out_cell_walls(out_cell_walls)
  );

  maze_carver_checker #(
    .GRID_W(GRID_W), .GRID_H(GRID_H), .TRIES_PER_CELL(TRIES_PER_CELL)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_dir_draw(in_dir_draw), .in_read_x(in_read_x), .in_read_y(in_read_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_finished(out_finished),
    .out_carved(out_carved), .out_top_x(out_top_x), .out_top_y(out_top_y),
    .out_far_x(out_far_x), .out_far_y(out_far_y), .out_far_len(out_far_len),
    .out_cell_walls(out_cell_walls),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result stall: modes of no stall, light, heavy and a periodic pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One transaction on the input channel; bursts separated by random gaps
  task automatic send_op(op_t op, dir_t d, logic [COORD_W-1:0] rx,
                         logic [COORD_W-1:0] ry);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_dir_draw <= d;
    in_read_x   <= rx;
    in_read_y   <= ry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Hold off the sender until every expected result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= CFG_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly in-grid start cells, with edges and off-grid values now and then
  function automatic logic [COORD_W-1:0] pick_start_coord();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return '0;
    if (r < 4) return COORD_W'(GRID_W - 1);
    if (r == 4) return '1;
    if (r == 5) return COORD_W'($urandom_range(20, 31));
    return COORD_W'($urandom_range(0, 19));
  endfunction

  initial begin
    logic [COORD_W-1:0] cur_sx, cur_sy, rx, ry;
    int items_sent, phase_len, r;
    bit start_ok;
    op_t op;
    dir_t d;

    cur_sx     = '0;
    cur_sy     = '0;
    items_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: untouched stores, empty stack, no-op and off-grid reads
    send_op(OP_READ, DIR_UP, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_UP, 5'd0, 5'd0);
    send_op(OP_NOP, DIR_LEFT, 5'd7, 5'd3);
    send_op(OP_READ, DIR_DOWN, 5'd31, 5'd31);
    drain_results();

    // Corner start: edge draws, carving, visited neighbour, wall reads
    write_reg(REG_START_X, 5'd19);
    write_reg(REG_START_Y, 5'd19);
    send_op(OP_START, DIR_UP, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_DOWN, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_RIGHT, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_UP, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_DOWN, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_LEFT, 5'd0, 5'd0);
    send_op(OP_READ, DIR_UP, 5'd19, 5'd19);
    send_op(OP_READ, DIR_UP, 5'd18, 5'd18);
    send_op(OP_READ, DIR_UP, 5'd19, 5'd31);
    send_op(OP_READ, DIR_UP, 5'd31, 5'd0);
    send_op(OP_NOP, DIR_RIGHT, 5'd0, 5'd0);
    drain_results();

    // Off-grid start: finished at once, draws ignored, stores cleared
    write_reg(REG_START_X, 5'd31);
    write_reg(REG_START_Y, 5'd31);
    send_op(OP_START, DIR_UP, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_LEFT, 5'd0, 5'd0);
    send_op(OP_READ, DIR_UP, 5'd0, 5'd0);
    drain_results();

    // Origin start: edge draws on the other two sides
    write_reg(REG_START_X, 5'd0);
    write_reg(REG_START_Y, 5'd0);
    send_op(OP_START, DIR_UP, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_UP, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_LEFT, 5'd0, 5'd0);
    send_op(OP_DRAW, DIR_RIGHT, 5'd0, 5'd0);
    send_op(OP_READ, DIR_UP, 5'd1, 5'd0);
    items_sent = 23;

    // Random mazes: start, then a long walk of draws with reads and noise
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) != 0) begin
          cur_sx = pick_start_coord();
          write_reg(REG_START_X, cur_sx);
        end
        if ($urandom_range(0, 1) != 0) begin
          cur_sy = pick_start_coord();
          write_reg(REG_START_Y, cur_sy);
        end
      end
      start_ok = (cur_sx < GRID_W) && (cur_sy < GRID_H);
      send_op(OP_START, dir_t'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 31)),
              COORD_W'($urandom_range(0, 31)));
      phase_len = start_ok ? $urandom_range(40, 400) : $urandom_range(2, 6);
      items_sent++;
      for (int k = 0; k < phase_len && items_sent < ITEM_TARGET; k++) begin
        r  = $urandom_range(0, 99);
        d  = dir_t'($urandom_range(0, 3));
        rx = COORD_W'($urandom_range(0, 31));
        ry = COORD_W'($urandom_range(0, 31));
        if (r < 82) begin
          op = OP_DRAW;
        end else if (r < 90) begin
          op = OP_READ;
          rx = COORD_W'($urandom_range(0, GRID_W - 1));
          ry = COORD_W'($urandom_range(0, GRID_H - 1));
        end else if (r < 94) begin
          op = OP_READ;
        end else if (r < 98) begin
          op = OP_NOP;
        end else begin
          op = OP_START;
        end
        send_op(op, d, rx, ry);
        items_sent++;
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
